>>> sv/hwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hwd_pkg;

    localparam int CHILD_W = 9;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int BITS_W  = 3;

    // Input tdata layout, lowest bit first.
    localparam int IDX_LSB   = 0;
    localparam int LEFT_LSB  = IDX_LSB + CHILD_W;
    localparam int RIGHT_LSB = LEFT_LSB + CHILD_W;
    localparam int NSYM_LSB  = RIGHT_LSB + CHILD_W;
    localparam int CODE_LSB  = NSYM_LSB + SYM_W;
    localparam int S_FIELDS_W = CODE_LSB + CODE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = SYM_W;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_DECODE = 2'd1,
        OP_START  = 2'd2
    } t_op;

    typedef struct packed {
        logic [CHILD_W-1:0] left;
        logic [CHILD_W-1:0] right;
        logic [SYM_W-1:0]   symbol;
    } t_node;

    // Request from the walker to the output stage.
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             done;
    } t_sym_evt;

endpackage

`default_nettype wire

>>> sv/hwd_node_ram.sv
// Node table memory: one write port, one read port, registered read data.
// Depends on hwd_pkg for the node entry type.
`timescale 1ns / 1ps
`default_nettype none

module hwd_node_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire hwd_pkg::t_node      i_wdata,
    input  wire logic                i_re,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output      hwd_pkg::t_node      o_rdata
);
    import hwd_pkg::*;

    t_node r_mem [DEPTH];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/hwd_walker.sv
// Tree-walk sequencer: loads nodes, walks one code bit per cycle unless stalled.
// Depends on hwd_pkg and instantiates hwd_node_ram.
`timescale 1ns / 1ps
`default_nettype none

module hwd_walker #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    output      logic                           o_item_ready,
    input  wire logic [hwd_pkg::S_TUSER_W-1:0]  i_op,
    input  wire logic [hwd_pkg::CHILD_W-1:0]    i_node_index,
    input  wire logic [hwd_pkg::CHILD_W-1:0]    i_left_child,
    input  wire logic [hwd_pkg::CHILD_W-1:0]    i_right_child,
    input  wire logic [hwd_pkg::SYM_W-1:0]      i_node_symbol,
    input  wire logic [hwd_pkg::CODE_W-1:0]     i_code_byte,
    input  wire logic [hwd_pkg::COUNT_W-1:0]    i_total,
    output      hwd_pkg::t_sym_evt              o_evt,
    input  wire logic                           i_evt_ready
);
    import hwd_pkg::*;

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [CHILD_W:0]   NODE_LIM = (CHILD_W+1)'(NODE_COUNT);
    localparam logic [CHILD_W-1:0] ROOT_IDX = CHILD_W'(NODE_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FLUSH
    } t_state;

    t_state              r_state;
    logic [CHILD_W-1:0]  r_cur_left;
    logic [CHILD_W-1:0]  r_cur_right;
    logic [CHILD_W-1:0]  r_cur_idx;
    logic [CHILD_W-1:0]  r_nxt_idx;
    logic [CHILD_W-1:0]  r_root_left;
    logic [CHILD_W-1:0]  r_root_right;
    logic                r_at_root;
    logic [CODE_W-1:0]   r_code;
    logic [BITS_W-1:0]   r_bits_left;
    logic                r_nxt_oob;
    logic [COUNT_W-1:0]  r_count;

    t_node               ram_rdata;
    t_node               nn;
    t_node               wr_node;
    logic                accept;
    logic                we;
    logic                dec_go;
    logic                leaf;
    logic                last_sym;
    logic                step_adv;
    logic                stop_after;
    logic                step_cont;
    logic                bit_sel;
    logic [CHILD_W-1:0]  src_left;
    logic [CHILD_W-1:0]  src_right;
    logic [CHILD_W-1:0]  nxt;
    logic                nxt_oob;
    logic                rd_en;

    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;
    assign we           = accept && (i_op == OP_WRITE) && ({1'b0, i_node_index} < NODE_LIM);
    assign dec_go       = accept && (i_op == OP_DECODE) && (r_count < i_total);

    // An entry beyond the table reads as an all-zero leaf.
    assign nn       = r_nxt_oob ? '0 : ram_rdata;
    assign leaf     = (nn.left == '0) && (nn.right == '0);
    assign last_sym = ((r_count + COUNT_W'(1)) == i_total);

    assign step_adv   = leaf ? i_evt_ready : 1'b1;
    assign stop_after = (r_bits_left == '0) || (leaf && last_sym);
    assign step_cont  = (r_state == S_STEP) && step_adv && !stop_after;

    // Next read address: from the current node on a new byte, otherwise from
    // the node just fetched (or the root after a leaf).
    always_comb begin
        if (r_state == S_IDLE) begin
            src_left  = r_at_root ? r_root_left  : r_cur_left;
            src_right = r_at_root ? r_root_right : r_cur_right;
            bit_sel   = i_code_byte[CODE_W-1];
        end else begin
            src_left  = leaf ? r_root_left  : nn.left;
            src_right = leaf ? r_root_right : nn.right;
            bit_sel   = r_code[CODE_W-1];
        end
    end

    assign nxt     = bit_sel ? src_right : src_left;
    assign nxt_oob = !({1'b0, nxt} < NODE_LIM);
    assign rd_en   = (dec_go || step_cont) && !nxt_oob;

    assign wr_node = '{left: i_left_child, right: i_right_child, symbol: i_node_symbol};

    hwd_node_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_node_index[ADDR_W-1:0]),
        .i_wdata (wr_node),
        .i_re    (rd_en),
        .i_raddr (nxt[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_evt.push   = (r_state == S_STEP) && leaf;
    assign o_evt.flush  = (r_state == S_FLUSH);
    assign o_evt.symbol = nn.symbol;
    assign o_evt.done   = last_sym;

    // Shadow copy of the root's children so a walk can restart without a read.
    always_ff @(posedge i_clk) begin
        if (we && (i_node_index == ROOT_IDX)) begin
            r_root_left  <= i_left_child;
            r_root_right <= i_right_child;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_at_root <= 1'b1;
            r_count   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (t_op'(i_op))
                            OP_WRITE: begin
                                // The cached children of the node the walk
                                // rests on follow any rewrite of that node.
                                if (we && (i_node_index == r_cur_idx)) begin
                                    r_cur_left  <= i_left_child;
                                    r_cur_right <= i_right_child;
                                end
                            end
                            OP_START: begin
                                r_at_root <= 1'b1;
                                r_count   <= '0;
                            end
                            OP_DECODE: begin
                                if (dec_go) begin
                                    r_state     <= S_STEP;
                                    r_code      <= i_code_byte << 1;
                                    r_bits_left <= BITS_W'(CODE_W - 1);
                                    r_nxt_oob   <= nxt_oob;
                                    r_nxt_idx   <= nxt;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    if (step_adv) begin
                        if (leaf) begin
                            r_count   <= r_count + COUNT_W'(1);
                            r_at_root <= 1'b1;
                        end else begin
                            r_cur_left  <= nn.left;
                            r_cur_right <= nn.right;
                            r_cur_idx   <= r_nxt_idx;
                            r_at_root   <= 1'b0;
                        end
                        if (stop_after) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_bits_left <= r_bits_left - BITS_W'(1);
                            r_code      <= r_code << 1;
                            r_nxt_oob   <= nxt_oob;
                            r_nxt_idx   <= nxt;
                        end
                    end
                end
                S_FLUSH: begin
                    if (i_evt_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/hwd_out_stage.sv
// Output stage: holds one symbol back until it is known whether it is the
// last of its code byte, then registers it for the output stream. Uses hwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hwd_out_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hwd_pkg::t_sym_evt          i_evt,
    output      logic                       o_evt_ready,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic [hwd_pkg::SYM_W-1:0]  o_symbol,
    output      logic                       o_last,
    output      logic                       o_done
);
    import hwd_pkg::*;

    logic             r_hold_v;
    logic [SYM_W-1:0] r_hold_symbol;
    logic             r_hold_done;
    logic             r_out_v;
    logic [SYM_W-1:0] r_out_symbol;
    logic             r_out_last;
    logic             r_out_done;

    logic out_free;
    logic evt_take;
    logic move;

    assign out_free    = !r_out_v || i_ready;
    assign o_evt_ready = !r_hold_v || out_free;
    assign evt_take    = (i_evt.push || i_evt.flush) && o_evt_ready;
    assign move        = evt_take && r_hold_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_v <= 1'b0;
            end
            // A following symbol proves the held one is not last; a flush
            // proves that it is.
            if (move) begin
                r_out_v      <= 1'b1;
                r_out_symbol <= r_hold_symbol;
                r_out_last   <= i_evt.flush;
                r_out_done   <= r_hold_done;
            end
            if (evt_take) begin
                r_hold_v <= i_evt.push;
                if (i_evt.push) begin
                    r_hold_symbol <= i_evt.symbol;
                    r_hold_done   <= i_evt.done;
                end
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_symbol = r_out_symbol;
    assign o_last   = r_out_last;
    assign o_done   = r_out_done;

endmodule

`default_nettype wire

>>> sv/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: stream ports, the symbol total
// register, the walker with its node memory, and the output stage.
// Depends on hwd_pkg, hwd_walker, hwd_node_ram and hwd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one item at a time on its input stream. tuser selects the
// operation: a node write stores left child, right child and symbol in the
// node table; a start item puts the walk at the root (the last table entry)
// and clears the symbol count. A decode item consumes one code byte, most
// significant bit first: the block accepts the byte and reads the first
// child, then steps through the bits, each step taking the node read in the
// step before and, but for the last, issuing the next node memory read,
// until the byte ends or the total is reached; it then releases the final
// symbol of the byte with tlast set. That chain of dependent reads through
// the registered node memory sets the pace, and a stalled output holds the
// walk. A byte that finds the symbol total already reached is taken without
// starting a walk and produces nothing. Each symbol is held back by one place
// so that tlast can mark the last one of its byte, and tuser is set on the
// symbol that brings the count to the configured total. The total is written
// through the configuration channel, which is always ready; it should only be
// written while no decode is in progress. The node table is not cleared at
// reset, so every entry the walk can reach must be written before decoding.
module huffman_tree_walk_decoder #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // node_index, left_child, right_child, node_symbol, code_byte; zero fill
    input  wire logic [hwd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  wire logic [hwd_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // symbol
    output      logic [hwd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output      logic                             m_axis_tlast,
    // stream_done
    output      logic [hwd_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [hwd_pkg::COUNT_W-1:0]      i_cfg_data
);
    import hwd_pkg::*;

    logic [COUNT_W-1:0] r_total_symbols;
    t_sym_evt           evt;
    logic               evt_ready;
    logic               out_done;

    // The total is a plain register; a transfer on the configuration channel
    // replaces it and leaves the walk and the count untouched.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_symbols <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_total_symbols <= i_cfg_data;
        end
    end

    hwd_walker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (s_axis_tvalid),
        .o_item_ready  (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_node_index  (s_axis_tdata[IDX_LSB   +: CHILD_W]),
        .i_left_child  (s_axis_tdata[LEFT_LSB  +: CHILD_W]),
        .i_right_child (s_axis_tdata[RIGHT_LSB +: CHILD_W]),
        .i_node_symbol (s_axis_tdata[NSYM_LSB  +: SYM_W]),
        .i_code_byte   (s_axis_tdata[CODE_LSB  +: CODE_W]),
        .i_total       (r_total_symbols),
        .o_evt         (evt),
        .i_evt_ready   (evt_ready)
    );

    hwd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_symbol    (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_done      (out_done)
    );

    assign m_axis_tuser = M_TUSER_W'(out_done);

endmodule

`default_nettype wire

>>> sv/hwd_checker.sv
// Port-level checks for the Huffman tree-walk decoder, bound to the top level.
// Depends on hwd_pkg and huffman_tree_walk_decoder.
`timescale 1ns / 1ps
`default_nettype none

module hwd_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [hwd_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [hwd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                             m_axis_tlast,
    input wire logic [hwd_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import hwd_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output transfer changed while stalled");

    // Reaching the total ends the byte, so that symbol must carry tlast.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("stream done without tlast");

    // Node writes, starts and unused codes finish in the cycle they are taken.
    a_single_cycle_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_DECODE) |=>
            s_axis_tready)
        else $error("non-decode item blocked the input");

endmodule

bind huffman_tree_walk_decoder hwd_checker u_hwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the Huffman tree-walk decoder: builds code trees,
// decodes random byte streams and checks every symbol against its own tree walk.
// Depends on hwd_pkg and huffman_tree_walk_decoder.
`timescale 1ns / 1ps

module tb;
    import hwd_pkg::*;

    localparam int         NODES       = 512;
    localparam logic [8:0] ROOT_NODE   = 9'd511;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE      = 24;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done;
    } t_decoded;

    typedef struct packed {
        logic [S_TUSER_W-1:0] op;
        logic [S_TDATA_W-1:0] data;
    } t_request;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data    = '0;

    // Shadow of the decoder: node table, walk position, symbol count and total.
    t_node              tree_mem [NODES];
    logic [8:0]         walk_node    = ROOT_NODE;
    logic [COUNT_W-1:0] symbols_out  = '0;
    logic [COUNT_W-1:0] symbol_total = '0;
    t_decoded           expected_syms [$];

    // Stimulus side: items waiting to be sent, and which table entries hold data.
    t_request pending [$];
    bit       node_loaded [NODES];
    int       loaded_list [$];

    int send_idle_pct = 28;
    int recv_idle_pct = 55;
    bit hold_req      = 1'b0;
    bit hold_over     = 1'b0;
    int hold_count    = 0;
    bit item_taken    = 1'b0;
    bit cfg_taken     = 1'b0;
    int err_count     = 0;
    int cycle_count   = 0;

    huffman_tree_walk_decoder #(
        .NODE_COUNT(NODES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Applies one accepted transfer to the shadow state and queues the symbols
    // that a code byte yields, marking the final one of the byte.
    function automatic void walk_request(input logic [S_TUSER_W-1:0] op,
                                         input logic [S_TDATA_W-1:0] data);
        t_node      here;
        t_node      child;
        logic [8:0] next_node;
        logic [7:0] code;
        t_decoded   batch [8];
        int         n;
        n = 0;
        code = data[CODE_LSB +: CODE_W];
        case (op)
            OP_WRITE: begin
                tree_mem[data[IDX_LSB +: CHILD_W]] = '{left:   data[LEFT_LSB +: CHILD_W],
                                                       right:  data[RIGHT_LSB +: CHILD_W],
                                                       symbol: data[NSYM_LSB +: SYM_W]};
            end
            OP_START: begin
                walk_node = ROOT_NODE;
                symbols_out = '0;
            end
            OP_DECODE: begin
                for (int b = 7; b >= 0; b--) begin
                    // Bits left over once the total is reached are dropped.
                    if (symbols_out < symbol_total) begin
                        here = tree_mem[walk_node];
                        next_node = code[b] ? here.right : here.left;
                        child = tree_mem[next_node];
                        walk_node = next_node;
                        if (child.left == '0 && child.right == '0) begin
                            symbols_out = symbols_out + COUNT_W'(1);
                            walk_node = ROOT_NODE;
                            batch[n] = '{symbol: child.symbol, last: 1'b0,
                                         done: symbols_out == symbol_total};
                            n++;
                        end
                    end
                end
                if (n > 0)
                    batch[n-1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    expected_syms.push_back(batch[k]);
            end
            default: ;
        endcase
    endfunction

    function automatic void push_request(input logic [1:0] op, input logic [8:0] idx,
                                         input logic [8:0] left, input logic [8:0] right,
                                         input logic [7:0] sym, input logic [7:0] code);
        t_request req;
        req.op = op;
        req.data = '0;
        req.data[IDX_LSB +: CHILD_W]   = idx;
        req.data[LEFT_LSB +: CHILD_W]  = left;
        req.data[RIGHT_LSB +: CHILD_W] = right;
        req.data[NSYM_LSB +: SYM_W]    = sym;
        req.data[CODE_LSB +: CODE_W]   = code;
        pending.push_back(req);
        if (op == OP_WRITE && !node_loaded[idx]) begin
            node_loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
    endfunction

    function automatic void queue_node(input logic [8:0] idx, input logic [8:0] left,
                                       input logic [8:0] right, input logic [7:0] sym);
        push_request(OP_WRITE, idx, left, right, sym, 8'($urandom));
    endfunction

    function automatic void queue_code(input logic [7:0] code);
        push_request(OP_DECODE, 9'($urandom), 9'($urandom), 9'($urandom), 8'($urandom), code);
    endfunction

    function automatic void queue_op(input logic [1:0] op);
        push_request(op, 9'($urandom), 9'($urandom), 9'($urandom), 8'($urandom),
                     8'($urandom));
    endfunction

    // Children of stray writes only point at entries that already hold data,
    // so no walk ever reads an entry that was never written.
    function automatic logic [8:0] pick_loaded();
        return 9'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    endfunction

    // Grows a full binary tree from the root by splitting random leaves, on
    // fresh table entries, and queues the writes that load it.
    function automatic void grow_tree(input int leaves);
        int open_nodes [$];
        bit claimed [NODES];
        int kids [2];
        int pick;
        int parent;
        open_nodes.push_back(int'(ROOT_NODE));
        claimed[0] = 1'b1;
        claimed[ROOT_NODE] = 1'b1;
        for (int k = 1; k < leaves; k++) begin
            pick = $urandom_range(open_nodes.size() - 1);
            parent = open_nodes[pick];
            open_nodes.delete(pick);
            for (int c = 0; c < 2; c++) begin
                do kids[c] = $urandom_range(NODES - 2, 1); while (claimed[kids[c]]);
                claimed[kids[c]] = 1'b1;
                open_nodes.push_back(kids[c]);
            end
            queue_node(9'(parent), 9'(kids[0]), 9'(kids[1]), 8'($urandom));
        end
        foreach (open_nodes[i])
            queue_node(9'(open_nodes[i]), '0, '0, 8'($urandom));
    endfunction

    // Mostly well-formed streams (tree, start, code bytes), with stray node
    // writes, restarts mid-walk and unused operations mixed in.
    task automatic run_random(input int count);
        int made;
        int r;
        int leaves;
        int bytes;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 15) begin
                leaves = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 2);
                grow_tree(leaves);
                queue_op(OP_START);
                repeat (3) queue_code(8'($urandom));
                made += 2 * leaves + 3;
            end else if (r < 55) begin
                bytes = $urandom_range(6, 2);
                queue_op(OP_START);
                repeat (bytes) queue_code(8'($urandom));
                made += bytes + 1;
            end else if (r < 80) begin
                bytes = $urandom_range(3, 1);
                repeat (bytes) queue_code(8'($urandom));
                made += bytes;
            end else if (r < 90) begin
                if ($urandom_range(3) == 0)
                    queue_node(9'($urandom), '0, '0, 8'($urandom));
                else
                    queue_node(9'($urandom), pick_loaded(), pick_loaded(), 8'($urandom));
                made++;
            end else if (r < 95) begin
                queue_op(OP_START);
                made++;
            end else begin
                queue_op(OP_UNUSED);
            end
        end
    endtask

    task automatic write_total(input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every item has gone in and every symbol has come out, then
    // gives a byte that yields nothing time to finish its walk.
    task automatic drain_results();
        while (pending.size() != 0 || s_axis_tvalid || expected_syms.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Input driver: a new item is offered once the previous one has been taken.
    always @(negedge i_clk) begin : feeder
        t_request req;
        if (!s_axis_tvalid || item_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= req.op;
                s_axis_tdata  <= req.data;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req && !hold_over) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES)
                hold_over <= 1'b1;
        end else begin
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Transfer monitor: feeds accepted items to the shadow and checks symbols.
    always @(posedge i_clk) begin : monitor
        t_decoded want;
        item_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken  <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                symbol_total = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                walk_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_syms.size() == 0) begin
                    $error("symbol %0h delivered with nothing expected", m_axis_tdata);
                    err_count++;
                end else begin
                    want = expected_syms.pop_front();
                    if (m_axis_tdata !== want.symbol) begin
                        $error("symbol: expected %0h, got %0h", want.symbol, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        err_count++;
                    end
                    if (m_axis_tuser[0] !== want.done) begin
                        $error("stream_done: expected %0b, got %0b", want.done, m_axis_tuser[0]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A total of zero: a code byte must yield nothing.
        write_total('0);
        queue_node(9'd0, '0, '0, 8'hA5);
        queue_node(ROOT_NODE, 9'd1, 9'd2, 8'h3C);
        queue_node(9'd1, '0, '0, 8'h00);
        queue_node(9'd2, '0, '0, 8'hFF);
        queue_code(8'hFF);
        queue_op(OP_UNUSED);
        drain_results();

        // One-bit codes give eight symbols a byte; the total runs out mid-byte.
        write_total(32'd20);
        queue_op(OP_START);
        queue_code(8'h00);
        queue_code(8'hFF);
        queue_code(8'h5A);
        queue_code(8'h33);
        queue_op(OP_START);
        // A root whose left child is none lands on entry 0; a 0 bit at node 3
        // leads back to the root without giving a symbol.
        queue_node(ROOT_NODE, '0, 9'd3, 8'h11);
        queue_node(9'd3, ROOT_NODE, 9'd1, 8'h22);
        queue_code(8'hC6);
        queue_code(8'h3F);
        queue_op(OP_START);
        queue_code(8'hA0);
        drain_results();

        // Largest total; the output side holds off long enough to fill the block.
        write_total('1);
        grow_tree(2);
        queue_op(OP_START);
        repeat (6) queue_code(8'($urandom));
        hold_req = 1'b1;
        run_random(30);
        drain_results();

        send_idle_pct = 55;
        recv_idle_pct = 28;
        write_total(32'($urandom_range(40, 5)));
        queue_op(OP_START);
        run_random(30);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_total(32'd1);
        queue_op(OP_START);
        run_random(20);
        drain_results();

        write_total(32'($urandom));
        queue_op(OP_START);
        run_random(25);
        drain_results();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/hwd_pkg.sv
sv/hwd_node_ram.sv
sv/hwd_walker.sv
sv/hwd_out_stage.sv
sv/huffman_tree_walk_decoder.sv
sv/hwd_checker.sv
sim/tb.sv
